/* design/guillotine_rect_packer_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the guillotine rectangle packer
// Shared property forms used by the top-level checks.
// ---------------------------------------------------------------------------
`ifndef GUILLOTINE_RECT_PACKER_ASSERT_SVH
`define GUILLOTINE_RECT_PACKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/grp_pkg.sv */
// ---------------------------------------------------------------------------
// grp_pkg
// Types and constants shared by the guillotine rectangle packer.
// ---------------------------------------------------------------------------
`default_nettype none

package grp_pkg;

  localparam int MAX_FREE   = 64;
  localparam int COORD_BITS = 16;
  localparam int CNT_W      = $clog2(MAX_FREE + 1);
  localparam int ADDR_W     = $clog2(MAX_FREE);
  localparam int AREA_W     = 2 * COORD_BITS;
  localparam int BOUND_W    = COORD_BITS + 1;

  localparam logic [COORD_BITS-1:0] BIN_W_RESET = COORD_BITS'(1024);
  localparam logic [COORD_BITS-1:0] BIN_H_RESET = COORD_BITS'(1024);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [BOUND_W-1:0]    bound_t;
  typedef logic [AREA_W-1:0]     area_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [ADDR_W-1:0]     addr_t;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_EARLIER = 2'd3
  } status_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } rect_t;

  // command into the best-fit unit
  typedef struct packed {
    logic  clear;
    logic  valid;
    addr_t idx;
    rect_t rect;
  } fit_cmd_t;

  // state of the best-fit unit
  typedef struct packed {
    logic  busy;
    logic  found;
    addr_t idx;
    rect_t rect;
  } fit_stat_t;

  typedef struct packed {
    coord_t  pos_x;
    coord_t  pos_y;
    bound_t  bound_width;
    bound_t  bound_height;
    status_t status;
  } result_t;

endpackage

`default_nettype wire

/* design/grp_chan_if.sv */
// ---------------------------------------------------------------------------
// grp_in_if / grp_out_if
// Valid/ready channels for items and results of the rectangle packer.
// ---------------------------------------------------------------------------
`default_nettype none

interface grp_in_if
  import grp_pkg::*;
;
  logic   valid;
  logic   ready;
  logic   start_new;
  coord_t item_width;
  coord_t item_height;

  modport source (output valid, start_new, item_width, item_height, input ready);
  modport sink   (input valid, start_new, item_width, item_height, output ready);
endinterface

interface grp_out_if
  import grp_pkg::*;
;
  logic   valid;
  logic   ready;
  coord_t pos_x;
  coord_t pos_y;
  bound_t bound_width;
  bound_t bound_height;
  logic [1:0] status;

  modport source (output valid, pos_x, pos_y, bound_width, bound_height, status,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, bound_width, bound_height, status,
                  output ready);
endinterface

`default_nettype wire

/* design/grp_fit_unit.sv */
// ---------------------------------------------------------------------------
// grp_fit_unit
// Shared area multiplier and compare: tracks the first smallest fitting entry.
// ---------------------------------------------------------------------------
`default_nettype none

module grp_fit_unit
  import grp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire fit_cmd_t  cmd,
  input  wire coord_t    item_w,
  input  wire coord_t    item_h,
  output fit_stat_t      stat
);

  logic  s1_v_r;
  logic  s1_fit_r;
  area_t s1_area_r;
  addr_t s1_idx_r;
  rect_t s1_rect_r;

  logic  found_r;
  area_t best_area_r;
  addr_t best_idx_r;
  rect_t best_rect_r;

  logic  take;

  // strict less-than keeps the earliest entry on a tie
  assign take = s1_v_r && s1_fit_r && (!found_r || (s1_area_r < best_area_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.valid;
      if (cmd.clear) begin
        found_r <= 1'b0;
      end else if (take) begin
        found_r <= 1'b1;
      end
    end
    s1_fit_r  <= (cmd.rect.w >= item_w) && (cmd.rect.h >= item_h);
    s1_area_r <= area_t'(cmd.rect.w) * area_t'(cmd.rect.h);
    s1_idx_r  <= cmd.idx;
    s1_rect_r <= cmd.rect;
    if (take) begin
      best_area_r <= s1_area_r;
      best_idx_r  <= s1_idx_r;
      best_rect_r <= s1_rect_r;
    end
  end

  assign stat = '{busy: s1_v_r, found: found_r, idx: best_idx_r, rect: best_rect_r};

endmodule

`default_nettype wire

/* design/grp_ctrl.sv */
// ---------------------------------------------------------------------------
// grp_ctrl
// Sequencer and free-list memory: scan, split, compact and append.
// ---------------------------------------------------------------------------
`default_nettype none

module grp_ctrl
  import grp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  grp_in_if.sink       in_chan,
  input  wire coord_t  bin_w,
  input  wire coord_t  bin_h,
  output logic         res_valid,
  input  wire logic    res_ready,
  output result_t      res,
  output cnt_t         free_count
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_APP_R, S_APP_B, S_DONE
  } state_t;

  state_t  state_r, state_nxt;
  coord_t  iw_r, iw_nxt;
  coord_t  ih_r, ih_nxt;
  cnt_t    count_r, count_nxt;
  logic    failed_r, failed_nxt;
  bound_t  bw_r, bw_nxt;
  bound_t  bh_r, bh_nxt;
  cnt_t    idx_r, idx_nxt;
  logic    rv_r, rv_nxt;
  addr_t   rid_r, rid_nxt;
  logic    wv_r, wv_nxt;
  addr_t   wa_r, wa_nxt;
  coord_t  pos_x_r, pos_x_nxt;
  coord_t  pos_y_r, pos_y_nxt;
  status_t status_r, status_nxt;

  rect_t   mem [MAX_FREE];
  rect_t   rd_data_r;
  logic    mem_we;
  addr_t   mem_wa;
  rect_t   mem_wd;
  addr_t   mem_ra;

  fit_cmd_t  fit_cmd;
  fit_stat_t fit_st;
  rect_t     fr;
  logic      split_r;
  logic      split_b;
  logic [CNT_W:0] need;
  bound_t    sum_x;
  bound_t    sum_y;

  grp_fit_unit u_fit (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (fit_cmd),
    .item_w (iw_r),
    .item_h (ih_r),
    .stat   (fit_st)
  );

  assign fr      = fit_st.rect;
  assign split_r = iw_r < fr.w;
  assign split_b = ih_r < fr.h;
  assign need    = {1'b0, count_r} - (CNT_W+1)'(1)
                 + (CNT_W+1)'(split_r) + (CNT_W+1)'(split_b);
  assign sum_x   = {1'b0, fr.x} + {1'b0, iw_r};
  assign sum_y   = {1'b0, fr.y} + {1'b0, ih_r};

  assign in_chan.ready = (state_r == S_IDLE);
  assign res = '{pos_x: pos_x_r, pos_y: pos_y_r, bound_width: bw_r,
                 bound_height: bh_r, status: status_r};
  assign free_count = count_r;

  always_comb begin
    state_nxt  = state_r;
    iw_nxt     = iw_r;
    ih_nxt     = ih_r;
    count_nxt  = count_r;
    failed_nxt = failed_r;
    bw_nxt     = bw_r;
    bh_nxt     = bh_r;
    idx_nxt    = idx_r;
    rv_nxt     = 1'b0;
    rid_nxt    = rid_r;
    wv_nxt     = 1'b0;
    wa_nxt     = wa_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = rd_data_r;
    mem_ra     = idx_r[ADDR_W-1:0];
    res_valid  = 1'b0;
    fit_cmd    = '{clear: 1'b0, valid: rv_r, idx: rid_r, rect: rd_data_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          iw_nxt        = in_chan.item_width;
          ih_nxt        = in_chan.item_height;
          idx_nxt       = '0;
          fit_cmd.clear = 1'b1;
          pos_x_nxt     = '0;
          pos_y_nxt     = '0;
          if (in_chan.start_new) begin
            mem_we     = 1'b1;
            mem_wd     = '{x: '0, y: '0, w: bin_w, h: bin_h};
            count_nxt  = cnt_t'(1);
            failed_nxt = 1'b0;
            bw_nxt     = '0;
            bh_nxt     = '0;
            state_nxt  = S_SCAN;
          end else if (failed_r) begin
            status_nxt = ST_EARLIER;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_r < count_r) begin
          rv_nxt  = 1'b1;
          rid_nxt = idx_r[ADDR_W-1:0];
          idx_nxt = idx_r + cnt_t'(1);
        end else if (!rv_r && !fit_st.busy) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!fit_st.found) begin
          status_nxt = ST_NOFIT;
          failed_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else if (need > (CNT_W+1)'(MAX_FREE)) begin
          status_nxt = ST_FULL;
          failed_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          status_nxt = ST_PLACED;
          pos_x_nxt  = fr.x;
          pos_y_nxt  = fr.y;
          if (sum_x > bw_r) bw_nxt = sum_x;
          if (sum_y > bh_r) bh_nxt = sum_y;
          idx_nxt    = cnt_t'(fit_st.idx) + cnt_t'(1);
          state_nxt  = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // read one entry ahead, write it back one slot lower
        if (idx_r < count_r) begin
          wv_nxt  = 1'b1;
          wa_nxt  = addr_t'(idx_r - cnt_t'(1));
          idx_nxt = idx_r + cnt_t'(1);
        end
        if (wv_r) begin
          mem_we = 1'b1;
          mem_wa = wa_r;
          mem_wd = rd_data_r;
        end
        if (!(idx_r < count_r) && !wv_r) begin
          count_nxt = count_r - cnt_t'(1);
          state_nxt = S_APP_R;
        end
      end
      S_APP_R: begin
        if (split_r) begin
          mem_we    = 1'b1;
          mem_wa    = count_r[ADDR_W-1:0];
          mem_wd    = '{x: fr.x + iw_r, y: fr.y, w: fr.w - iw_r, h: ih_r};
          count_nxt = count_r + cnt_t'(1);
        end
        state_nxt = S_APP_B;
      end
      S_APP_B: begin
        if (split_b) begin
          mem_we    = 1'b1;
          mem_wa    = count_r[ADDR_W-1:0];
          mem_wd    = '{x: fr.x, y: fr.y + ih_r, w: fr.w, h: fr.h - ih_r};
          count_nxt = count_r + cnt_t'(1);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      failed_r <= 1'b0;
      bw_r     <= '0;
      bh_r     <= '0;
      idx_r    <= '0;
      rv_r     <= 1'b0;
      wv_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      failed_r <= failed_nxt;
      bw_r     <= bw_nxt;
      bh_r     <= bh_nxt;
      idx_r    <= idx_nxt;
      rv_r     <= rv_nxt;
      wv_r     <= wv_nxt;
    end
    iw_r     <= iw_nxt;
    ih_r     <= ih_nxt;
    rid_r    <= rid_nxt;
    wa_r     <= wa_nxt;
    pos_x_r  <= pos_x_nxt;
    pos_y_r  <= pos_y_nxt;
    status_r <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_r <= mem[mem_ra];
  end

endmodule

`default_nettype wire

/* design/guillotine_rect_packer.sv */
// ---------------------------------------------------------------------------
// guillotine_rect_packer
// Best-area-fit guillotine packer with a 64-entry ordered free list.
// ---------------------------------------------------------------------------
// Items are worked one at a time and the input is not ready while one is in
// work. A placed item goes through accept, scan (one free-list read a cycle
// through the single memory read port, then two stages of the shared area
// multiplier and compare), decision, compaction of the entries above the
// chosen one (same read port, one entry moved a cycle, plus a step to retire
// the last move), up to two appends on the single write port, and hand-off.
// A failed item goes through accept, scan, decision and hand-off; an item
// ignored after an earlier failure goes from accept straight to hand-off. A
// finished result sits in an output register, so the next item is taken while
// it waits. The free list needs no clearing after reset: only entries below
// the count are read.
// Registers: bin_width at byte address 0, bin_height at 4 (low 16 bits).
// ---------------------------------------------------------------------------
`default_nettype none

`include "guillotine_rect_packer_assert.svh"

module guillotine_rect_packer
  import grp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  grp_in_if.sink           in_chan,
  grp_out_if.source        out_chan,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam logic REG_BIN_WIDTH  = 1'b0;
  localparam logic REG_BIN_HEIGHT = 1'b1;

  coord_t  bin_w_r;
  coord_t  bin_h_r;
  logic    cfg_wr;

  logic    res_valid;
  logic    res_ready;
  result_t res;
  cnt_t    free_count;

  logic    out_valid_r;
  result_t out_r;

  // config: word address picks the register, writes land in the access phase
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr[2])
      REG_BIN_WIDTH:  cfg_prdata = {16'b0, bin_w_r};
      REG_BIN_HEIGHT: cfg_prdata = {16'b0, bin_h_r};
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_w_r <= BIN_W_RESET;
      bin_h_r <= BIN_H_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_BIN_WIDTH) bin_w_r <= cfg_pwdata[COORD_BITS-1:0];
      else                               bin_h_r <= cfg_pwdata[COORD_BITS-1:0];
    end
  end

  grp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .bin_w      (bin_w_r),
    .bin_h      (bin_h_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .free_count (free_count)
  );

  // output register: refill when empty or when the held word is taken
  assign res_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) out_r <= res;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.pos_x        = out_r.pos_x;
  assign out_chan.pos_y        = out_r.pos_y;
  assign out_chan.bound_width  = out_r.bound_width;
  assign out_chan.bound_height = out_r.bound_height;
  assign out_chan.status       = out_r.status;

  // an accepted word keeps the input closed for at least the next cycle
  `GRP_ASSERT_NEXT(a_busy_after_accept, in_chan.valid && in_chan.ready, !in_chan.ready, "input reopened right after accept")
  // no result is offered while the sequencer waits for an item
  `GRP_ASSERT_NOW(a_no_result_when_idle, in_chan.ready, !res_valid, "result offered while idle")
  // the free list never holds more than its depth
  `GRP_ASSERT_NOW(a_count_bound, 1'b1, free_count <= cnt_t'(MAX_FREE), "free count beyond depth")
  // an item that is not placed reports the origin
  `GRP_ASSERT_NOW(a_fail_pos_zero, out_valid_r && (out_r.status != ST_PLACED), (out_r.pos_x == '0) && (out_r.pos_y == '0), "failed word with nonzero position")

endmodule

`default_nettype wire
